// ===== design/twrb_pkg.sv =====
// ----------------------------------------------------------------------------
// twrb_pkg
// Shared types and constants for the three-wire register bus master.
// ----------------------------------------------------------------------------
package twrb_pkg;

  // Register reset values and the width of the configuration data.
  localparam int unsigned CfgWidth = 16;
  localparam logic [CfgWidth-1:0] HALF_RESET = 16'd500;
  localparam logic [CfgWidth-1:0] GAP_RESET = 16'd10000;

  // Configuration register indexes.
  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_GAP = 1'b1;

  // Request codes carried in the command field.
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Stream widths, padded to whole bytes.
  localparam int unsigned InWidth = 24;
  localparam int unsigned OutWidth = 16;

  // Sequencer phase.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FRAME = 2'd1,
    PH_GAP   = 2'd2
  } phase_t;

  // One input tick, unpacked from the stream.
  typedef struct packed {
    logic [1:0] command;
    logic [5:0] address;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  // One result: pin levels and status for the tick.
  typedef struct packed {
    logic       chip_select_n;
    logic       serial_clock;
    logic       data_out;
    logic       data_drive;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
  } result_t;

endpackage

// ===== design/twrb_in_reg.sv =====
// ----------------------------------------------------------------------------
// twrb_in_reg
// Input register: captures one tick from the input stream and unpacks it.
// ----------------------------------------------------------------------------
module twrb_in_reg
  import twrb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [InWidth-1:0] in_tdata,
  input  logic               advance,
  output logic               item_valid,
  output item_t              item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  take;

  // A new transfer is taken when the register is empty or drains this cycle.
  assign in_tready = !valid_r || advance;
  assign take = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register, unpacked from the lowest bit up.
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.command    <= in_tdata[1:0];
      item_r.address    <= in_tdata[7:2];
      item_r.write_data <= in_tdata[15:8];
      item_r.sda_in     <= in_tdata[16];
    end
  end

  assign item_valid = valid_r;
  assign item = item_r;

endmodule

// ===== design/twrb_core.sv =====
// ----------------------------------------------------------------------------
// twrb_core
// Frame sequencer: advances the serial state by one tick per item and forms
// the pin levels and status for that tick.
// ----------------------------------------------------------------------------
module twrb_core
  import twrb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CfgWidth-1:0] half_period_ticks,
  input  logic [CfgWidth-1:0] gap_ticks,
  input  logic                step,
  input  item_t               item,
  output result_t             result
);

  phase_t        phase_r, phase_nxt;
  logic [3:0]    bit_index_r, bit_index_nxt;
  logic          high_half_r, high_half_nxt;
  logic [15:0]   tick_count_r, tick_count_nxt;
  logic [15:0]   frame_shift_r, frame_shift_nxt;
  logic          is_read_r, is_read_nxt;
  logic [7:0]    rx_shift_r, rx_shift_nxt;
  logic          drive_r, drive_nxt;
  logic          read_done;
  logic [15:0]   half;
  logic [3:0]    bit_dec;
  logic          start_read;

  // A zero half period behaves as one tick.
  assign half = (half_period_ticks == '0) ? 16'd1 : half_period_ticks;
  assign bit_dec = bit_index_r - 4'd1;
  assign start_read = (item.command == CMD_READ);

  // Next state for one tick, then a possible frame start.
  always_comb begin
    phase_nxt       = phase_r;
    bit_index_nxt   = bit_index_r;
    high_half_nxt   = high_half_r;
    tick_count_nxt  = tick_count_r;
    frame_shift_nxt = frame_shift_r;
    is_read_nxt     = is_read_r;
    rx_shift_nxt    = rx_shift_r;
    drive_nxt       = drive_r;
    read_done       = 1'b0;

    case (phase_r)
      PH_FRAME: begin
        if (tick_count_r < half) begin
          tick_count_nxt = tick_count_r + 16'd1;
        end else begin
          tick_count_nxt = 16'd1;
          if (!high_half_r) begin
            // Rising clock edge: sample the data bits of a read.
            high_half_nxt = 1'b1;
            if (is_read_r && (bit_index_r < 4'd8)) begin
              rx_shift_nxt = {rx_shift_r[6:0], item.sda_in};
            end
          end else if (bit_index_r == 4'd0) begin
            // Last high half done: close the frame.
            phase_nxt     = PH_GAP;
            high_half_nxt = 1'b1;
            drive_nxt     = 1'b0;
            read_done     = is_read_r;
          end else begin
            // Next bit; a read releases the pin from the turnaround bit on.
            bit_index_nxt = bit_dec;
            high_half_nxt = 1'b0;
            drive_nxt     = !is_read_r || (bit_dec >= 4'd9);
          end
        end
      end
      PH_GAP: begin
        if (tick_count_r < gap_ticks) begin
          tick_count_nxt = tick_count_r + 16'd1;
        end else begin
          phase_nxt      = PH_IDLE;
          tick_count_nxt = 16'd0;
        end
      end
      default: begin
      end
    endcase

    // Requests are honored only when the bus is idle after this tick.
    if ((phase_nxt == PH_IDLE) &&
        ((item.command == CMD_WRITE) || (item.command == CMD_READ))) begin
      phase_nxt       = PH_FRAME;
      is_read_nxt     = start_read;
      frame_shift_nxt = {item.address, start_read, 1'b0,
                         start_read ? 8'd0 : item.write_data};
      bit_index_nxt   = 4'd15;
      high_half_nxt   = 1'b0;
      tick_count_nxt  = 16'd1;
      drive_nxt       = 1'b1;
    end
  end

  // Pin levels reflect the state after this tick.
  always_comb begin
    result.chip_select_n = (phase_nxt != PH_FRAME);
    result.serial_clock  = (phase_nxt == PH_FRAME) ? high_half_nxt : 1'b1;
    result.data_drive    = (phase_nxt == PH_FRAME) && drive_nxt;
    result.data_out      = result.data_drive && frame_shift_nxt[bit_index_nxt];
    result.busy_res      = (phase_nxt != PH_IDLE);
    result.read_valid    = read_done;
    result.read_data     = rx_shift_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      bit_index_r   <= 4'd0;
      high_half_r   <= 1'b1;
      tick_count_r  <= 16'd0;
      frame_shift_r <= 16'd0;
      is_read_r     <= 1'b0;
      rx_shift_r    <= 8'd0;
      drive_r       <= 1'b0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      bit_index_r   <= bit_index_nxt;
      high_half_r   <= high_half_nxt;
      tick_count_r  <= tick_count_nxt;
      frame_shift_r <= frame_shift_nxt;
      is_read_r     <= is_read_nxt;
      rx_shift_r    <= rx_shift_nxt;
      drive_r       <= drive_nxt;
    end
  end

  // Outside a frame the clock idles high and the data pin is released.
  a_idle_clock_high: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_FRAME) |-> (high_half_r && !drive_r))
    else $error("clock low or pin driven outside a frame");

  // The idle phase always leaves the tick counter cleared.
  a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (tick_count_r == 16'd0))
    else $error("tick counter not cleared in idle");

  // Within a frame a half period is always under way.
  a_frame_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FRAME) |-> (tick_count_r != 16'd0))
    else $error("tick counter zero during a frame");

  // State moves only when an item is processed.
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(tick_count_r))
    else $error("sequencer state changed without an item");

endmodule

// ===== design/twrb_out_reg.sv =====
// ----------------------------------------------------------------------------
// twrb_out_reg
// Output register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module twrb_out_reg
  import twrb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  result_t             result,
  output logic                advance,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutWidth-1:0] out_tdata
);

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  // The register can load when empty or when its result leaves this cycle.
  assign advance = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (step) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_r <= result;
    end
  end

  // Pack from the lowest bit up, padded with zeros.
  assign out_tvalid = valid_r;
  assign out_tdata = {2'b00, result_r.read_data, result_r.read_valid,
                      result_r.busy_res, result_r.data_drive, result_r.data_out,
                      result_r.serial_clock, result_r.chip_select_n};

endmodule

// ===== design/three_wire_register_bus_master.sv =====
// ----------------------------------------------------------------------------
// three_wire_register_bus_master
// Three-wire serial master for panel register access, one timebase tick per
// stream transfer.
// ----------------------------------------------------------------------------
// Each input transfer is one tick; its command may start a write or a read
// frame (ignored while busy) and its sda_in is the data pin level sensed on
// that tick. Each input transfer yields exactly one output transfer with the
// pin levels (chip select, serial clock, data level and drive) and status for
// that tick. A frame is 6 address bits, a read/write bit, a turnaround bit and
// 8 data bits, MSB first; each bit is a low and a high half of
// half_period_ticks ticks, followed by a gap of max(gap_ticks, 1) busy ticks.
// Each input transfer passes through one input register, then the sequencer
// step into the output register. Throughput is one tick per clock cycle while
// the receiver does not stall; the sequencer step is a single short stage.
// When the receiver stalls, the output register holds its result and the
// input register holds one more tick, after which in_tready drops; no tick
// is lost or advanced. Synchronous reset returns the bus to idle (clock
// high, chip select high, pin released), clears the receive byte and loads
// the registers with a half period of 500 and a gap of 10000 ticks.
// Configuration is written through cfg_we / cfg_index / cfg_data while no
// tick is in flight.
// ----------------------------------------------------------------------------
module three_wire_register_bus_master
  import twrb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Input stream.
  input  logic                in_tvalid,
  output logic                in_tready,
  // command[1:0], address[7:2], write_data[15:8], sda_in[16], zeros[23:17]
  input  logic [InWidth-1:0]  in_tdata,
  // Output stream.
  output logic                out_tvalid,
  input  logic                out_tready,
  // chip_select_n[0], serial_clock[1], data_out[2], data_drive[3],
  // busy_res[4], read_valid[5], read_data[13:6], zeros[15:14]
  output logic [OutWidth-1:0] out_tdata,
  // Configuration write port.
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CfgWidth-1:0] cfg_data
);

  logic [CfgWidth-1:0] half_period_r;
  logic [CfgWidth-1:0] gap_r;
  logic                advance;
  logic                item_valid;
  item_t               item;
  result_t             result;
  logic                step;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_RESET;
      gap_r         <= GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HALF_PERIOD: half_period_r <= cfg_data;
        CFG_GAP:         gap_r         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A held tick is processed when the output register can take its result.
  assign step = item_valid && advance;

  twrb_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  twrb_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .half_period_ticks (half_period_r),
    .gap_ticks         (gap_r),
    .step              (step),
    .item              (item),
    .result            (result)
  );

  twrb_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .result     (result),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== sim/three_wire_register_bus_master_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_wire_register_bus_master_checker
// Watches the tick streams of the three-wire bus master, predicts the pin
// levels for every accepted tick and compares them with the results.
// ----------------------------------------------------------------------------
// A copy of the serial sequencer runs one step per accepted input transfer
// and queues the pin levels it expects. Each output transfer is compared
// field by field with the oldest queued entry. Configuration writes are
// applied to the local copy of the registers on the edge where they happen.
// When the stimulus is done, any entry still queued counts as a failure.
// ----------------------------------------------------------------------------
module three_wire_register_bus_master_checker
  import twrb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [InWidth-1:0]  in_tdata,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutWidth-1:0] out_tdata,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CfgWidth-1:0] cfg_data,
  input  logic                stim_done,
  output int                  mismatch_count
);

  // Only the first few failures are printed; all of them are counted.
  localparam int PrintLimit = 40;

  // Local copy of the registers.
  logic [15:0] half_cfg;
  logic [15:0] gap_cfg;

  // Local copy of the sequencer state.
  phase_t      phase;
  logic [4:0]  bit_idx;
  logic        clk_high;
  logic [15:0] tick_cnt;
  logic [15:0] frame_bits;
  logic        rd_frame;
  logic [7:0]  rx_shift;
  logic        pin_driven;

  // Pin levels expected for ticks that are still in flight.
  result_t     pin_levels_q[$];
  logic        leftover_checked = 1'b0;

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    if (mismatch_count < PrintLimit) begin
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got_v, want_v);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got_v,
                             input logic [7:0] want_v);
    if (got_v !== want_v) begin
      report_mismatch(name, int'(got_v), int'(want_v));
    end
  endtask

  // One timebase tick of the serial sequencer; returns the pin levels.
  task automatic step_bus_engine(input item_t tick, output result_t pins);
    logic [15:0] half_len;
    logic        read_done;
    half_len  = (half_cfg == 16'd0) ? 16'd1 : half_cfg;
    read_done = 1'b0;

    // Advance the running frame or gap.
    case (phase)
      PH_FRAME: begin
        if (tick_cnt < half_len) begin
          tick_cnt = tick_cnt + 16'd1;
        end else begin
          tick_cnt = 16'd1;
          if (!clk_high) begin
            // Rising clock: data bits of a read are sampled here.
            clk_high = 1'b1;
            if (rd_frame && bit_idx < 5'd8) begin
              rx_shift = {rx_shift[6:0], tick.sda_in};
            end
          end else if (bit_idx == 5'd0) begin
            phase      = PH_GAP;
            clk_high   = 1'b1;
            pin_driven = 1'b0;
            read_done  = rd_frame;
          end else begin
            // Falling clock: move on to the next bit; a read lets go of the
            // pin from the turnaround bit on.
            bit_idx    = bit_idx - 5'd1;
            clk_high   = 1'b0;
            pin_driven = !rd_frame || (bit_idx >= 5'd9);
          end
        end
      end
      PH_GAP: begin
        if (tick_cnt < gap_cfg) begin
          tick_cnt = tick_cnt + 16'd1;
        end else begin
          phase    = PH_IDLE;
          tick_cnt = 16'd0;
        end
      end
      default: ;
    endcase

    // A request is taken only when the bus is idle.
    if (phase == PH_IDLE && (tick.command == CMD_WRITE || tick.command == CMD_READ)) begin
      phase      = PH_FRAME;
      rd_frame   = (tick.command == CMD_READ);
      frame_bits = {tick.address, rd_frame, 1'b0, rd_frame ? 8'h00 : tick.write_data};
      bit_idx    = 5'd15;
      clk_high   = 1'b0;
      tick_cnt   = 16'd1;
      pin_driven = 1'b1;
    end

    pins.chip_select_n = (phase != PH_FRAME);
    pins.serial_clock  = (phase == PH_FRAME) ? clk_high : 1'b1;
    pins.data_drive    = (phase == PH_FRAME) && pin_driven;
    pins.data_out      = pins.data_drive ? frame_bits[bit_idx[3:0]] : 1'b0;
    pins.busy_res      = (phase != PH_IDLE);
    pins.read_valid    = read_done;
    pins.read_data     = rx_shift;
  endtask

  always @(posedge clk) begin
    item_t   tick;
    result_t want;
    result_t got;
    if (!rst_n) begin
      half_cfg   = HALF_RESET;
      gap_cfg    = GAP_RESET;
      phase      = PH_IDLE;
      bit_idx    = 5'd0;
      clk_high   = 1'b1;
      tick_cnt   = 16'd0;
      frame_bits = 16'd0;
      rd_frame   = 1'b0;
      rx_shift   = 8'd0;
      pin_driven = 1'b0;
      pin_levels_q.delete();
    end else begin
      // Register writes take effect before any later tick.
      if (cfg_we) begin
        if (cfg_index == CFG_HALF_PERIOD) begin
          half_cfg = cfg_data;
        end else if (cfg_index == CFG_GAP) begin
          gap_cfg = cfg_data;
        end
      end

      // Predict the result of each accepted tick.
      if (in_tvalid && in_tready) begin
        tick.command    = in_tdata[1:0];
        tick.address    = in_tdata[7:2];
        tick.write_data = in_tdata[15:8];
        tick.sda_in     = in_tdata[16];
        step_bus_engine(tick, want);
        pin_levels_q.push_back(want);
      end

      // Compare each result transfer with the oldest prediction.
      if (out_tvalid && out_tready) begin
        got.chip_select_n = out_tdata[0];
        got.serial_clock  = out_tdata[1];
        got.data_out      = out_tdata[2];
        got.data_drive    = out_tdata[3];
        got.busy_res      = out_tdata[4];
        got.read_valid    = out_tdata[5];
        got.read_data     = out_tdata[13:6];
        if (pin_levels_q.size() == 0) begin
          report_mismatch("result with no tick waiting", int'(out_tdata), 0);
        end else begin
          want = pin_levels_q.pop_front();
          check_field("chip_select_n", 8'(got.chip_select_n), 8'(want.chip_select_n));
          check_field("serial_clock", 8'(got.serial_clock), 8'(want.serial_clock));
          check_field("data_out", 8'(got.data_out), 8'(want.data_out));
          check_field("data_drive", 8'(got.data_drive), 8'(want.data_drive));
          check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
          check_field("read_valid", 8'(got.read_valid), 8'(want.read_valid));
          check_field("read_data", got.read_data, want.read_data);
        end
      end

      // Anything still queued once the stimulus has finished never arrived.
      if (stim_done && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (pin_levels_q.size() != 0) begin
          report_mismatch("results never delivered", pin_levels_q.size(), 0);
        end
      end
    end
  end

endmodule

// ===== sim/three_wire_register_bus_master_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_wire_register_bus_master_tb
// Stimulus and verdict for the three-wire register bus master.
// ----------------------------------------------------------------------------
// Runs the block through a series of register settings: the reset values,
// one-tick and zero half periods, zero and full-scale gaps, and a full-scale
// half period. Each setting gets directed or random ticks carrying write and
// read requests, spare commands and random data pin levels. The sender works
// in bursts with random gaps and the receiver stalls in changing patterns.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module three_wire_register_bus_master_tb;
  import twrb_pkg::*;

  // Spare command code; the block treats it as a plain tick.
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // Data pin level used by a run of ticks.
  localparam int LEVEL_LOW    = 0;
  localparam int LEVEL_HIGH   = 1;
  localparam int LEVEL_RANDOM = 2;

  // Position of busy_res in out_tdata.
  localparam int BusyBit = 4;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InWidth-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutWidth-1:0] out_tdata;
  logic                cfg_we = 1'b0;
  logic                cfg_index = 1'b0;
  logic [CfgWidth-1:0] cfg_data = '0;
  logic                stim_done = 1'b0;
  int                  mismatch_count;

  // Transfer bookkeeping.
  int   sent_ticks = 0;
  int   taken_results = 0;
  logic last_busy = 1'b0;
  int   burst_left = 0;

  // Receiver stall pattern state.
  int       rx_mode = 0;
  int       rx_mode_left = 0;
  logic [7:0] rx_cyc = 8'd0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  three_wire_register_bus_master dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  three_wire_register_bus_master_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .stim_done      (stim_done),
    .mismatch_count (mismatch_count)
  );

  // Count result transfers and remember whether the bus was last seen busy.
  always @(posedge clk) begin
    if (!rst_n) begin
      taken_results <= 0;
      last_busy     <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      taken_results <= taken_results + 1;
      last_busy     <= out_tdata[BusyBit];
    end
  end

  // Receiver: switches between no stalls, random, periodic and heavy stalls.
  always @(negedge clk) begin
    rx_cyc <= rx_cyc + 8'd1;
    if (rx_mode_left == 0) begin
      rx_mode      <= $urandom_range(0, 3);
      rx_mode_left <= $urandom_range(32, 400);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= (rx_cyc[2:0] != 3'd5);
      default: out_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // Offer one tick; called and returns at a falling edge.
  task automatic send_tick(input logic [1:0] cmd, input logic [5:0] addr,
                           input logic [7:0] wdata, input logic sda);
    int idle_len;
    if (burst_left == 0) begin
      idle_len   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 32);
      repeat (idle_len) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, sda, wdata, addr, cmd};
    do @(posedge clk); while (!in_tready);
    sent_ticks++;
    @(negedge clk);
  endtask

  // A run of ticks that all carry the same request fields.
  task automatic tick_burst(input int n, input logic [1:0] cmd, input logic [5:0] addr,
                            input logic [7:0] wdata, input int sda_mode);
    logic sda;
    repeat (n) begin
      sda = (sda_mode == LEVEL_RANDOM) ? 1'($urandom_range(0, 1)) : (sda_mode == LEVEL_HIGH);
      send_tick(cmd, addr, wdata, sda);
    end
  endtask

  // Random ticks: mostly plain ticks, with requests and spare codes mixed in.
  task automatic random_ticks(input int n);
    logic [1:0] cmd;
    repeat (n) begin
      cmd = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3)) : CMD_TICK;
      send_tick(cmd, 6'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  // Tick the bus until the frame and gap are over and every result is back.
  task automatic drain_bus();
    forever begin
      while (last_busy) begin
        send_tick(CMD_TICK, 6'($urandom), 8'($urandom), 1'($urandom));
      end
      in_tvalid <= 1'b0;
      @(negedge clk);
      wait (taken_results == sent_ticks);
      @(negedge clk);
      if (!last_busy) break;
    end
  endtask

  task automatic write_reg(input logic idx, input logic [CfgWidth-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // New register setting once every tick in flight has come back; a frame or
  // gap under way carries on with the new timing.
  task automatic change_config(input logic [CfgWidth-1:0] half_len,
                               input logic [CfgWidth-1:0] gap_len);
    in_tvalid <= 1'b0;
    @(negedge clk);
    wait (taken_results == sent_ticks);
    repeat (4) @(negedge clk);
    write_reg(CFG_HALF_PERIOD, half_len);
    write_reg(CFG_GAP, gap_len);
  endtask

  // New register setting, written only once the bus is idle and quiet.
  task automatic set_config(input logic [CfgWidth-1:0] half_len,
                            input logic [CfgWidth-1:0] gap_len);
    drain_bus();
    change_config(half_len, gap_len);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset setting: one write frame, with requests and a spare code
    // arriving while it runs.
    tick_burst(1, CMD_WRITE, 6'h3F, 8'hA5, LEVEL_HIGH);
    tick_burst(100, CMD_TICK, 6'h00, 8'h00, LEVEL_RANDOM);
    tick_burst(3, CMD_READ, 6'h00, 8'h00, LEVEL_LOW);
    tick_burst(3, CMD_SPARE, 6'h2A, 8'hFF, LEVEL_HIGH);
    tick_burst(100, CMD_TICK, 6'h00, 8'h00, LEVEL_RANDOM);

    // Shortest half period and no gap, set while the first frame is still
    // in its first bit: back-to-back frames start on the first tick after
    // each gap.
    change_config(16'd1, 16'd0);
    tick_burst(70, CMD_WRITE, 6'h3F, 8'h00, LEVEL_LOW);
    tick_burst(70, CMD_READ, 6'h00, 8'hFF, LEVEL_HIGH);
    tick_burst(40, CMD_READ, 6'h2A, 8'h55, LEVEL_RANDOM);
    drain_bus();
    tick_burst(5, CMD_SPARE, 6'h15, 8'hAA, LEVEL_RANDOM);
    tick_burst(40, CMD_WRITE, 6'h15, 8'hAA, LEVEL_RANDOM);

    // Zero half period behaves as one tick per half.
    set_config(16'd0, 16'd1);
    tick_burst(40, CMD_WRITE, 6'h00, 8'hFF, LEVEL_LOW);
    tick_burst(40, CMD_READ, 6'h3F, 8'h00, LEVEL_RANDOM);

    // Random settings with short timing, so that many frames complete.
    repeat (4) begin
      set_config(16'($urandom_range(0, 3)),
                 ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 8)));
      random_ticks(90);
    end

    // Full-scale gap after a read frame.
    set_config(16'd1, 16'hFFFF);
    tick_burst(1, CMD_READ, 6'h2A, 8'h00, LEVEL_HIGH);
    tick_burst(40, CMD_TICK, 6'h00, 8'h00, LEVEL_RANDOM);

    // Full-scale half period; the gap is cut short so that the write starts
    // at once, and the run ends inside the first bit of the frame.
    change_config(16'hFFFF, 16'd0);
    tick_burst(1, CMD_WRITE, 6'h3F, 8'hFF, LEVEL_HIGH);
    random_ticks(60);

    // Let every result come back, then give the verdict.
    in_tvalid <= 1'b0;
    wait (taken_results == sent_ticks);
    repeat (8) @(negedge clk);
    stim_done <= 1'b1;
    repeat (3) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Timeout, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
